/* hw/rtl/lmtr_pkg.sv */
// ----------------------------------------------------------------------------
// lmtr_pkg
// shared types, codes and sizes of the longest-match token rewriter
// ----------------------------------------------------------------------------
package lmtr_pkg;

    localparam int DEF_DICT_ENTRIES    = 16;
    localparam int DEF_MAX_PATTERN_LEN = 8;
    localparam int QUEUE_DEPTH         = 2;

    localparam int SLOT_W  = 4;
    localparam int LEN_W   = 4;
    localparam int BYTE_W  = 8;
    localparam int PAT_W   = 64;
    localparam int FILL_W  = 4;
    localparam int OP_W    = 2;
    localparam int KIND_W  = 2;
    localparam int S_DATA_W = 80;

    localparam logic [OP_W-1:0] OP_CHAR = 2'd0;
    localparam logic [OP_W-1:0] OP_EOL  = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

    localparam logic [KIND_W-1:0] TK_LITERAL = 2'd0;
    localparam logic [KIND_W-1:0] TK_SYMBOL  = 2'd1;
    localparam logic [KIND_W-1:0] TK_EOL     = 2'd2;

    typedef enum logic [1:0] {
        CMD_CHAR,
        CMD_EOL,
        CMD_LOAD
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [BYTE_W-1:0]   char_byte;
        logic [SLOT_W-1:0]   entry_slot;
        logic [PAT_W-1:0]    pattern_bytes;
        logic [LEN_W-1:0]    pattern_len;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_RUN,
        ST_RESOLVE,
        ST_FLUSH,
        ST_EOL
    } back_state_t;

endpackage

/* hw/rtl/lmtr_front.sv */
// ----------------------------------------------------------------------------
// lmtr_front
// input stage: accepts words, drops unused ones and out-of-range loads, saturates and masks loads
// ----------------------------------------------------------------------------
module lmtr_front import lmtr_pkg::*; #(
    parameter int DICT_ENTRIES    = DEF_DICT_ENTRIES,
    parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic [OP_W-1:0]     s_tuser,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output cmd_t                cmd
);

    logic       valid_reg, valid_next;
    cmd_t       cmd_reg, cmd_next;
    logic       keep;
    logic [LEN_W-1:0] len_sat;
    logic [SLOT_W-1:0] slot_in;
    logic [LEN_W-1:0]  len_in;
    logic [PAT_W-1:0]  pat_in;

    assign s_tready  = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    assign slot_in = s_tdata[11:8];
    assign pat_in  = s_tdata[75:12];
    assign len_in  = s_tdata[79:76];

    always_comb begin
        len_sat = (int'(len_in) > MAX_PATTERN_LEN) ? LEN_W'(MAX_PATTERN_LEN) : len_in;
        keep = (s_tuser == OP_CHAR) || (s_tuser == OP_EOL) ||
               ((s_tuser == OP_LOAD) && (int'(slot_in) < DICT_ENTRIES));
        cmd_next = cmd_reg;
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = keep;
            cmd_next.char_byte  = s_tdata[7:0];
            cmd_next.entry_slot = slot_in;
            cmd_next.pattern_len = len_sat;
            case (s_tuser)
                OP_CHAR: cmd_next.kind = CMD_CHAR;
                OP_EOL:  cmd_next.kind = CMD_EOL;
                default: cmd_next.kind = CMD_LOAD;
            endcase
            for (int k = 0; k < PAT_W / BYTE_W; k++) begin
                cmd_next.pattern_bytes[k*BYTE_W +: BYTE_W] =
                    (k < int'(len_sat)) ? pat_in[k*BYTE_W +: BYTE_W] : '0;
            end
        end else if (cmd_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

endmodule

/* hw/rtl/lmtr_queue.sv */
// ----------------------------------------------------------------------------
// lmtr_queue
// short command queue between the input stage and the resolver
// ----------------------------------------------------------------------------
module lmtr_queue import lmtr_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = int'(count_reg) < DEPTH;
    assign out_valid = count_reg != '0;
    assign out_cmd   = store_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (int'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (int'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            store_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* hw/rtl/lmtr_back.sv */
// ----------------------------------------------------------------------------
// lmtr_back
// window, dictionary and longest-match resolver with registered output
// ----------------------------------------------------------------------------
module lmtr_back import lmtr_pkg::*; #(
    parameter int DICT_ENTRIES    = DEF_DICT_ENTRIES,
    parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cmd_valid,
    output logic              cmd_ready,
    input  cmd_t              cmd,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic [KIND_W-1:0] m_tuser,
    output logic              m_tlast
);

    back_state_t       state_reg, state_next;
    logic [BYTE_W-1:0] win_reg [MAX_PATTERN_LEN];
    logic [BYTE_W-1:0] win_next [MAX_PATTERN_LEN];
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [PAT_W-1:0]  pat_reg [DICT_ENTRIES];
    logic [LEN_W-1:0]  len_reg [DICT_ENTRIES];
    logic [LEN_W-1:0]  len_next [DICT_ENTRIES];
    logic              ok_reg [DICT_ENTRIES];
    logic              ok_next [DICT_ENTRIES];

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg, out_data_next;
    logic [KIND_W-1:0] out_kind_reg, out_kind_next;
    logic              out_last_reg, out_last_next;

    logic              hit [DICT_ENTRIES];
    logic              found [MAX_PATTERN_LEN + 1];
    logic [BYTE_W-1:0] found_slot [MAX_PATTERN_LEN + 1];
    logic [FILL_W-1:0] best_len, drop;
    logic [BYTE_W-1:0] best_slot;
    logic              out_free, do_resolve, load_wr;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign cmd_ready = (state_reg == ST_RUN);
    assign load_wr = cmd_ready && cmd_valid && (cmd.kind == CMD_LOAD);

    always_comb begin
        for (int i = 0; i < DICT_ENTRIES; i++) begin
            hit[i] = ok_reg[i] && (len_reg[i] != '0) && (len_reg[i] <= fill_reg);
            for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
                if ((k < int'(len_reg[i])) &&
                    (pat_reg[i][k*BYTE_W +: BYTE_W] != win_reg[k])) begin
                    hit[i] = 1'b0;
                end
            end
        end
        for (int l = 0; l <= MAX_PATTERN_LEN; l++) begin
            found[l] = 1'b0;
            found_slot[l] = '0;
            for (int i = 0; i < DICT_ENTRIES; i++) begin
                if (hit[i] && (int'(len_reg[i]) == l)) begin
                    found[l] = 1'b1;
                    found_slot[l] = BYTE_W'(i);
                end
            end
        end
        best_len  = '0;
        best_slot = '0;
        for (int l = 1; l <= MAX_PATTERN_LEN; l++) begin
            if (found[l]) begin
                best_len  = FILL_W'(l);
                best_slot = found_slot[l];
            end
        end
        drop = (best_len != '0) ? best_len : FILL_W'(1);
    end

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        win_next       = win_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        do_resolve     = 1'b0;
        for (int i = 0; i < DICT_ENTRIES; i++) begin
            len_next[i] = len_reg[i];
            ok_next[i]  = ok_reg[i];
            if (load_wr && (int'(cmd.entry_slot) == i)) begin
                len_next[i] = cmd.pattern_len;
                ok_next[i]  = cmd.pattern_len != '0;
            end
        end
        case (state_reg)
            ST_RUN: begin
                if (cmd_valid) begin
                    case (cmd.kind)
                        CMD_CHAR: begin
                            for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
                                if (int'(fill_reg) == k) begin
                                    win_next[k] = cmd.char_byte;
                                end
                            end
                            fill_next = fill_reg + 1'b1;
                            if (int'(fill_reg) + 1 >= MAX_PATTERN_LEN) begin
                                state_next = ST_RESOLVE;
                            end
                        end
                        CMD_EOL: state_next = ST_FLUSH;
                        default: ;
                    endcase
                end
            end
            ST_RESOLVE: begin
                if (out_free) begin
                    do_resolve    = 1'b1;
                    out_last_next = 1'b1;
                    state_next    = ST_RUN;
                end
            end
            ST_FLUSH: begin
                if (fill_reg == '0) begin
                    state_next = ST_EOL;
                end else if (out_free) begin
                    do_resolve    = 1'b1;
                    out_last_next = 1'b0;
                end
            end
            ST_EOL: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = TK_EOL;
                    out_data_next  = '0;
                    out_last_next  = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            default: state_next = ST_RUN;
        endcase
        if (do_resolve) begin
            out_valid_next = 1'b1;
            out_kind_next  = (best_len != '0) ? TK_SYMBOL : TK_LITERAL;
            out_data_next  = (best_len != '0) ? best_slot : win_reg[0];
            fill_next      = fill_reg - drop;
            for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
                win_next[k] = '0;
                for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
                    if (j == k + int'(drop)) begin
                        win_next[k] = win_reg[j];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_RUN;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
                win_reg[k] <= '0;
            end
            for (int i = 0; i < DICT_ENTRIES; i++) begin
                len_reg[i] <= '0;
                ok_reg[i]  <= 1'b0;
            end
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            win_reg       <= win_next;
            len_reg       <= len_next;
            ok_reg        <= ok_next;
        end
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        for (int i = 0; i < DICT_ENTRIES; i++) begin
            if (load_wr && (int'(cmd.entry_slot) == i)) begin
                pat_reg[i] <= cmd.pattern_bytes;
            end
        end
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        int'(fill_reg) <= MAX_PATTERN_LEN)
        else $error("window fill beyond window size");
    a_full_resolves: assert property (@(posedge aclk) disable iff (!aresetn)
        (int'(fill_reg) == MAX_PATTERN_LEN) |-> (state_reg == ST_RESOLVE))
        else $error("full window left unresolved");
    a_eol_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_kind_reg == TK_EOL)) |-> out_last_reg)
        else $error("end marker without last");
    a_eol_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EOL) |-> (fill_reg == '0))
        else $error("end marker with window not empty");
`endif

endmodule

/* hw/rtl/longest_match_token_rewriter_unit.sv */
// ----------------------------------------------------------------------------
// longest_match_token_rewriter_unit
// greedy longest-match tokenizer over a loadable dictionary of short patterns
// ----------------------------------------------------------------------------
// s_ channel: one word per character, end of line or dictionary load;
// s_tuser selects which. m_ channel: tokens, m_tuser the token kind,
// m_tdata the literal byte or slot index, m_tlast on the final token of
// a word. an input stage and a two-entry command queue sit in front of
// the resolver, so words are taken while a token waits at the output.
// throughput: one character or load word per cycle while the window
// fills; a character that fills the window moves the resolver into its
// resolve state, and an end of line moves it into a flush state that
// emits the remaining tokens, then into an end marker state. a word
// passes the input stage register and the command queue before the
// resolver, and each token leaves from a registered output. the resolver compares all slots in parallel.
// when m_tready is low the output register holds and the queue fills,
// then s_tready drops. reset empties the window and invalidates every
// dictionary slot; no clearing pass is needed.
// ----------------------------------------------------------------------------
module longest_match_token_rewriter_unit import lmtr_pkg::*; #(
    parameter int DICT_ENTRIES    = DEF_DICT_ENTRIES,
    parameter int MAX_PATTERN_LEN = DEF_MAX_PATTERN_LEN
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // char_byte, entry_slot, pattern_bytes, pattern_len
    input  logic [OP_W-1:0]     s_tuser,   // opcode
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [BYTE_W-1:0]   m_tdata,   // token_value
    output logic [KIND_W-1:0]   m_tuser,   // token_kind
    output logic                m_tlast
);

    logic f_valid, f_ready, b_valid, b_ready;
    cmd_t f_cmd, b_cmd;

    lmtr_front #(
        .DICT_ENTRIES(DICT_ENTRIES),
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready),
        .s_tdata(s_tdata), .s_tuser(s_tuser),
        .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
    );

    lmtr_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
        .out_valid(b_valid), .out_ready(b_ready), .out_cmd(b_cmd)
    );

    lmtr_back #(
        .DICT_ENTRIES(DICT_ENTRIES),
        .MAX_PATTERN_LEN(MAX_PATTERN_LEN)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd(b_cmd),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// drives characters, line ends and dictionary loads into the token rewriter
// under bursty input and stalled output, predicts every token with a local
// longest-match model and compares each token in order
// ----------------------------------------------------------------------------
module testbench;
    import lmtr_pkg::*;

    localparam int NSLOT = DEF_DICT_ENTRIES;
    localparam int WIN   = DEF_MAX_PATTERN_LEN;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] value;
        logic              last;
    } token_t;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;
    logic [OP_W-1:0]     s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    logic [BYTE_W-1:0]   m_tdata;
    logic [KIND_W-1:0]   m_tuser;
    logic                m_tlast;

    longest_match_token_rewriter_unit u_dut (.*);

    // local copy of the tokenizer state
    logic [BYTE_W-1:0] win_bytes [WIN];
    int                win_fill;
    logic [PAT_W-1:0]  dict_pat [NSLOT];
    int                dict_len [NSLOT];
    bit                written  [NSLOT];

    token_t expected_tokens[$];
    int     errors = 0;
    int     idle_cycles = 0;
    int     burst_left = 0;
    bit     sending_done = 0;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    function automatic bit head_matches(int slot, int len);
        for (int k = 0; k < len; k++)
            if (dict_pat[slot][8*k +: 8] != win_bytes[k]) return 0;
        return 1;
    endfunction

    function automatic void resolve_head(bit last);
        int best_len;
        int best_slot;
        int drop;
        token_t t;
        best_len = 0;
        best_slot = 0;
        for (int i = 0; i < NSLOT; i++) begin
            if (dict_len[i] == 0 || dict_len[i] > win_fill) continue;
            if (dict_len[i] >= best_len && head_matches(i, dict_len[i])) begin
                best_len = dict_len[i];
                best_slot = i;
            end
        end
        if (best_len > 0) begin
            t = '{TK_SYMBOL, BYTE_W'(best_slot), last};
            drop = best_len;
        end else begin
            t = '{TK_LITERAL, win_bytes[0], last};
            drop = 1;
        end
        expected_tokens.push_back(t);
        for (int k = 0; k < WIN; k++)
            win_bytes[k] = (k + drop < WIN) ? win_bytes[k + drop] : '0;
        win_fill -= drop;
    endfunction

    function automatic void predict_tokens(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch,
                                           logic [SLOT_W-1:0] slot, logic [PAT_W-1:0] pat,
                                           logic [LEN_W-1:0] len);
        int n;
        int l;
        case (op)
            OP_CHAR: begin
                if (win_fill < WIN) begin
                    win_bytes[win_fill] = ch;
                    win_fill++;
                end
                if (win_fill >= WIN) resolve_head(1);
            end
            OP_EOL: begin
                n = 0;
                while (win_fill > 0 && n < WIN) begin
                    resolve_head(0);
                    n++;
                end
                win_fill = 0;
                expected_tokens.push_back('{TK_EOL, 8'd0, 1'b1});
            end
            OP_LOAD: begin
                l = (len > WIN) ? WIN : int'(len);
                if (int'(slot) < NSLOT) begin
                    dict_len[slot] = l;
                    if (l > 0) begin
                        dict_pat[slot] = (l >= 8) ? pat : pat & ((64'd1 << (8*l)) - 1);
                        written[slot] = 1;
                    end
                end
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(logic [OP_W-1:0] op, logic [BYTE_W-1:0] ch,
                             logic [SLOT_W-1:0] slot, logic [PAT_W-1:0] pat,
                             logic [LEN_W-1:0] len);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                s_tvalid <= 0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1;
        s_tuser  <= op;
        s_tdata  <= {len, pat, slot, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_tokens(op, ch, slot, pat, len);
    endtask

    task automatic send_char(logic [BYTE_W-1:0] ch);
        send_word(OP_CHAR, ch, SLOT_W'($urandom), {$urandom, $urandom}, LEN_W'($urandom));
    endtask

    task automatic send_eol();
        send_word(OP_EOL, BYTE_W'($urandom), SLOT_W'($urandom), {$urandom, $urandom},
                  LEN_W'($urandom));
    endtask

    task automatic send_load(int slot, logic [PAT_W-1:0] pat, int len);
        send_word(OP_LOAD, BYTE_W'($urandom), SLOT_W'(slot), pat, LEN_W'(len));
    endtask

    // pick a byte from a written pattern so matches happen often
    function automatic logic [BYTE_W-1:0] dict_byte();
        int s;
        s = $urandom_range(0, NSLOT - 1);
        if (!written[s] || $urandom_range(0, 3) == 0) return BYTE_W'($urandom_range(0, 255));
        return dict_pat[s][8*$urandom_range(0, 7) +: 8];
    endfunction

    task automatic test_directed();
        send_char(8'h41); send_eol();
        send_eol();
        send_load(0, 64'h41, 1);
        send_load(1, 64'h4241, 2);
        send_load(2, 64'h4241, 2);
        send_load(15, 64'hFFFF_FFFF_FFFF_FFFF, 8);
        send_load(3, 64'h0000_0000_0000_0000, 8);
        send_load(4, 64'h0011_2233_4455_6677, 15);
        send_load(5, 64'h4241, 0);
        send_word(OP_UNUSED, 8'h41, 4'd6, 64'h41, 4'd1);
        send_char(8'h41); send_char(8'h42); send_char(8'h43); send_eol();
        for (int i = 0; i < 9; i++) send_char(8'hFF);
        send_eol();
        for (int i = 0; i < 8; i++) send_char(8'h00);
        send_eol();
    endtask

    task automatic test_loaded_lines();
        int len;
        for (int i = 0; i < NSLOT; i++) begin
            len = $urandom_range(1, 4);
            send_load(i, {$urandom, $urandom}, len);
        end
        for (int n = 0; n < 225; n++) begin
            case ($urandom_range(0, 19))
                0:  send_eol();
                1:  send_load($urandom_range(0, NSLOT - 1), {$urandom, $urandom},
                              $urandom_range(0, 15));
                2:  send_word(OP_UNUSED, BYTE_W'($urandom), SLOT_W'($urandom),
                              {$urandom, $urandom}, LEN_W'($urandom));
                3:  send_char(BYTE_W'($urandom_range(0, 255)));
                default: send_char(dict_byte());
            endcase
        end
        send_eol();
    endtask

    task automatic test_long_patterns();
        for (int i = 8; i < 12; i++)
            send_load(i, {$urandom, $urandom}, $urandom_range(5, 8));
        for (int n = 0; n < 50; n++) begin
            if ($urandom_range(0, 11) == 0) send_eol();
            else send_char(dict_byte());
        end
        send_eol();
    endtask

    // receiver stall pattern: runs of ready and not ready
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if ($urandom_range(0, 7) == 0) m_tready <= 1;
            else if ($urandom_range(0, 5) == 0) m_tready <= ~m_tready;
        end
    end

    always @(posedge aclk) begin
        token_t exp_tok;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: unexpected token kind %0d value %0h last %0b",
                         $time, m_tuser, m_tdata, m_tlast);
                errors++;
            end else begin
                exp_tok = expected_tokens.pop_front();
                if (m_tuser !== exp_tok.kind || m_tdata !== exp_tok.value
                    || m_tlast !== exp_tok.last) begin
                    $display("%0t: token mismatch expected %0d/%0h/%0b actual %0d/%0h/%0b",
                             $time, exp_tok.kind, exp_tok.value, exp_tok.last,
                             m_tuser, m_tdata, m_tlast);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any accepted word or token
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else if (aresetn && !(sending_done && expected_tokens.size() == 0))
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        aresetn  = 0;
        s_tvalid = 0;
        s_tdata  = '0;
        s_tuser  = '0;
        win_fill = 0;
        for (int k = 0; k < WIN; k++) win_bytes[k] = '0;
        for (int i = 0; i < NSLOT; i++) begin
            dict_pat[i] = '0;
            dict_len[i] = 0;
            written[i] = 0;
        end
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_directed();
        test_loaded_lines();
        test_long_patterns();
        s_tvalid <= 0;
        sending_done = 1;
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0 && expected_tokens.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
